// ----- rtl/search_result_table_assert.svh -----
// Assertion macros used by the checker file of the search result table.
`ifndef SEARCH_RESULT_TABLE_ASSERT_SVH
`define SEARCH_RESULT_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SRT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("search_result_table: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define SRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("search_result_table: next-cycle check failed");

`endif

// ----- rtl/srt_pkg.sv -----
// Types and constants of the search result table.
package srt_pkg;

   localparam int KEY_W   = 64;
   localparam int SCORE_W = 16;
   localparam int DEPTH_W = 8;
   localparam int KIND_W  = 2;

   // Slot index fold: the key is reduced a byte at a time in parallel
   localparam int BYTE_W    = 8;
   localparam int KEY_BYTES = KEY_W / BYTE_W;

   // Operation codes
   localparam logic FUNC_PROBE = 1'b0;
   localparam logic FUNC_STORE = 1'b1;

   // Bound kinds
   localparam logic [KIND_W-1:0] KIND_EXACT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOWER = 2'd1;
   localparam logic [KIND_W-1:0] KIND_UPPER = 2'd2;

   // One table slot as held in memory
   typedef struct packed {
      logic                      valid;
      logic [KEY_W-1:0]          key;
      logic signed [SCORE_W-1:0] score;
      logic [DEPTH_W-1:0]        depth;
      logic [KIND_W-1:0]         kind;
   } slot_type;

   // One request as captured at the input transfer
   typedef struct packed {
      logic                      func;
      logic [KEY_W-1:0]          key;
      logic signed [SCORE_W-1:0] score;
      logic [KIND_W-1:0]         kind;
      logic [DEPTH_W-1:0]        depth;
      logic signed [SCORE_W-1:0] alpha;
      logic signed [SCORE_W-1:0] beta;
   } item_type;

   // One response
   typedef struct packed {
      logic                      hit;
      logic signed [SCORE_W-1:0] found_score;
      logic                      written;
   } result_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INDEX,
      ST_RESOLVE
   } state_type;

endpackage

// ----- rtl/srt_index.sv -----
// Slot index unit: key modulo table size, a mask or a folded reciprocal reduction.
module srt_index #(
   parameter int TABLE_ENTRIES = 1024,
   parameter int IDX_W         = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [srt_pkg::KEY_W-1:0] key,
   output logic                     done,
   output logic [IDX_W-1:0]         index
);
   import srt_pkg::*;

   localparam bit POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;

   // Weight of each key byte: 2^(8*i) modulo the table size
   function automatic logic [KEY_BYTES*IDX_W-1:0] byte_weights();
      logic [KEY_BYTES*IDX_W-1:0] w;
      longint unsigned            p;
      w = '0;
      p = 1;
      for (int i = 0; i < KEY_BYTES; i++) begin
         w[i*IDX_W +: IDX_W] = IDX_W'(p % TABLE_ENTRIES);
         p = (p << BYTE_W) % TABLE_ENTRIES;
      end
      return w;
   endfunction

   generate
      if (POW2) begin : g_mask
         logic             done_ff;
         logic [IDX_W-1:0] idx_ff;

         // Low key bits give the slot directly
         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
            if (start) begin
               idx_ff <= key[IDX_W-1:0];
            end
         end

         assign done  = done_ff;
         assign index = idx_ff;
      end else begin : g_fold
         // sum of weighted bytes stays below 2^V_W; reciprocal fits in Q_W bits
         localparam int FOLD_STAGES = 4;
         localparam int V_W = IDX_W + BYTE_W + $clog2(KEY_BYTES);
         localparam int Q_W = V_W - IDX_W + 1;
         localparam int R_W = IDX_W + 1;
         localparam logic [R_W-1:0] MOD_N = R_W'(TABLE_ENTRIES);
         localparam logic [Q_W-1:0] RECIP = Q_W'((64'd1 << V_W) / TABLE_ENTRIES);
         localparam logic [KEY_BYTES*IDX_W-1:0] WEIGHTS = byte_weights();

         logic [FOLD_STAGES-1:0] stage_ff;
         logic [V_W-1:0]         sum_ff, sum_in;
         logic [Q_W-1:0]         quot_ff, quot_in;
         logic [R_W-1:0]         rem_ff, rem_in;
         logic [IDX_W-1:0]       idx_ff, idx_in;
         logic [V_W+Q_W-1:0]     scaled;
         logic [V_W-1:0]         rem_full;

         // Fold: each byte times its weight, summed
         always_comb begin
            sum_in = '0;
            for (int i = 0; i < KEY_BYTES; i++) begin
               sum_in = sum_in + V_W'(key[i*BYTE_W +: BYTE_W] * WEIGHTS[i*IDX_W +: IDX_W]);
            end
         end

         // Quotient estimate by reciprocal, low by at most one
         assign scaled  = (V_W+Q_W)'(sum_ff) * (V_W+Q_W)'(RECIP);
         assign quot_in = scaled[V_W +: Q_W];

         // Remainder below twice the table size
         assign rem_full = sum_ff - V_W'(quot_ff * MOD_N);
         assign rem_in   = rem_full[R_W-1:0];

         // Final correction
         always_comb begin
            if (rem_ff >= MOD_N) begin
               idx_in = IDX_W'(rem_ff - MOD_N);
            end else begin
               idx_in = rem_ff[IDX_W-1:0];
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               stage_ff <= '0;
            end else begin
               stage_ff <= {stage_ff[FOLD_STAGES-2:0], start};
            end
            if (start) begin
               sum_ff <= sum_in;
            end
            quot_ff <= quot_in;
            rem_ff  <= rem_in;
            idx_ff  <= idx_in;
         end

         assign done  = stage_ff[FOLD_STAGES-1];
         assign index = idx_ff;
      end
   endgenerate

endmodule

// ----- rtl/srt_mem.sv -----
// Slot memory: one write port, one read port with registered read data.
module srt_mem #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  srt_pkg::slot_type     wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     rd_addr,
   output srt_pkg::slot_type     rd_data
);
   import srt_pkg::*;

   slot_type mem [DEPTH];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/srt_eval.sv -----
// Probe and store decision on one slot read.
module srt_eval (
   input  srt_pkg::item_type   item,
   input  srt_pkg::slot_type   slot,
   output srt_pkg::result_type result,
   output logic                wr_en,
   output srt_pkg::slot_type   new_slot
);
   import srt_pkg::*;

   logic                      match;
   logic                      deep_enough;
   logic signed [SCORE_W-1:0] alpha_adj;
   logic signed [SCORE_W-1:0] beta_adj;
   logic                      use_score;

   assign match       = slot.valid && (slot.key == item.key);
   assign deep_enough = slot.depth >= item.depth;

   // Window narrowing by a stored bound
   always_comb begin
      alpha_adj = item.alpha;
      beta_adj  = item.beta;
      if (slot.kind == KIND_LOWER && slot.score > item.alpha) begin
         alpha_adj = slot.score;
      end
      if (slot.kind == KIND_UPPER && slot.score < item.beta) begin
         beta_adj = slot.score;
      end
   end

   assign use_score = (slot.kind == KIND_EXACT) || (alpha_adj >= beta_adj);

   // Depth-preferred replacement on a store; hit decision on a probe
   always_comb begin
      wr_en              = 1'b0;
      result.hit         = 1'b0;
      result.found_score = '0;
      result.written     = 1'b0;
      if (item.func == FUNC_STORE) begin
         wr_en          = !match || (slot.depth < item.depth);
         result.written = wr_en;
      end else if (match && deep_enough && use_score) begin
         result.hit         = 1'b1;
         result.found_score = slot.score;
      end
   end

   assign new_slot.valid = 1'b1;
   assign new_slot.key   = item.key;
   assign new_slot.score = item.score;
   assign new_slot.depth = item.depth;
   assign new_slot.kind  = item.kind;

endmodule

// ----- rtl/search_result_table.sv -----
// Search result table: direct-mapped, depth-preferred, one item in flight at a time.
// An item passes through the slot index, the slot read and the resolve step; the slot
// index is a mask when TABLE_ENTRIES is a power of two, else a 4-stage fold (byte fold,
// reciprocal, remainder, correction). A new item is taken only once the last has resolved.
// A finished result waits in an output register while the next item is taken.
// After reset a clearing pass over all TABLE_ENTRIES slots empties the table; no input taken.
module search_result_table #(
   parameter int TABLE_ENTRIES = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_func,
   input  logic [srt_pkg::KEY_W-1:0]           req_key,
   input  logic signed [srt_pkg::SCORE_W-1:0]  req_entry_score,
   input  logic [srt_pkg::KIND_W-1:0]          req_bound_type,
   input  logic [srt_pkg::DEPTH_W-1:0]         req_search_depth,
   input  logic signed [srt_pkg::SCORE_W-1:0]  req_window_low,
   input  logic signed [srt_pkg::SCORE_W-1:0]  req_window_high,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_hit,
   output logic signed [srt_pkg::SCORE_W-1:0]  rsp_found_score,
   output logic                                rsp_written
);
   import srt_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   item_type         item_ff;
   result_type       rsp_ff;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             req_accept;
   logic             rsp_free;
   logic             load_rsp;
   logic             idx_done;
   logic [IDX_W-1:0] idx;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   slot_type         mem_wdata;
   logic             mem_re;
   slot_type         slot_rd;
   result_type       eval_result;
   logic             eval_wr;
   slot_type         eval_slot;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   srt_index #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .IDX_W         (IDX_W)
   ) u_index (
      .clock (clock),
      .reset (reset),
      .start (req_accept),
      .key   (req_key),
      .done  (idx_done),
      .index (idx)
   );

   srt_mem #(
      .DEPTH  (TABLE_ENTRIES),
      .ADDR_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (idx),
      .rd_data (slot_rd)
   );

   srt_eval u_eval (
      .item     (item_ff),
      .slot     (slot_rd),
      .result   (eval_result),
      .wr_en    (eval_wr),
      .new_slot (eval_slot)
   );

   // Sequencer: clear, take item, index, read, resolve and write back
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      mem_we    = 1'b0;
      mem_waddr = idx;
      mem_wdata = '0;
      mem_re    = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_INDEX;
            end
         end
         ST_INDEX: begin
            if (idx_done) begin
               mem_re   = 1'b1;
               state_in = ST_RESOLVE;
            end
         end
         ST_RESOLVE: begin
            if (rsp_free) begin
               load_rsp  = 1'b1;
               mem_we    = eval_wr;
               mem_wdata = eval_slot;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.func  <= req_func;
         item_ff.key   <= req_key;
         item_ff.score <= req_entry_score;
         item_ff.kind  <= req_bound_type;
         item_ff.depth <= req_search_depth;
         item_ff.alpha <= req_window_low;
         item_ff.beta  <= req_window_high;
      end
      if (load_rsp) begin
         rsp_ff <= eval_result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_ff.hit;
   assign rsp_found_score = rsp_ff.found_score;
   assign rsp_written     = rsp_ff.written;

endmodule

// ----- rtl/srt_checker.sv -----
// Port-level checks of the search result table and their bind.
`include "search_result_table_assert.svh"

module srt_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic                               rsp_hit,
   input logic signed [srt_pkg::SCORE_W-1:0] rsp_found_score,
   input logic                               rsp_written
);
   import srt_pkg::*;

   // Only one item in flight: a transfer closes the input until it is done
   `SRT_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall)

   // A probe hit never comes with a write
   `SRT_ASSERT_IMPLY(a_hit_no_write, clock, reset, rsp_valid, !(rsp_hit && rsp_written))

   // A miss reports a zero score
   `SRT_ASSERT_IMPLY(a_miss_zero, clock, reset, rsp_valid && !rsp_hit, rsp_found_score == '0)

   // A stalled result holds
   `SRT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_hit) && $stable(rsp_found_score) && $stable(rsp_written))

endmodule

bind search_result_table srt_checker u_srt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_hit         (rsp_hit),
   .rsp_found_score (rsp_found_score),
   .rsp_written     (rsp_written)
);

// ----- verif/search_result_table_test.sv -----
// Self-checking testbench for the search result table: random and directed probes and stores.
module search_result_table_test;
   import srt_pkg::*;

   localparam int TABLE_ENTRIES  = 1024;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_ITEMS   = 400;
   localparam int POOL_SIZE      = 32;
   localparam int DRAIN_CYCLES   = 12;
   // Kind code with no bound meaning; stored as given
   localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;

   logic clock;
   logic reset = 1'b1;

   logic                      req_valid        = 1'b0;
   logic                      req_stall;
   logic                      req_func         = FUNC_PROBE;
   logic [KEY_W-1:0]          req_key          = '0;
   logic signed [SCORE_W-1:0] req_entry_score  = '0;
   logic [KIND_W-1:0]         req_bound_type   = KIND_EXACT;
   logic [DEPTH_W-1:0]        req_search_depth = '0;
   logic signed [SCORE_W-1:0] req_window_low   = '0;
   logic signed [SCORE_W-1:0] req_window_high  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall        = 1'b0;
   logic                      rsp_hit;
   logic signed [SCORE_W-1:0] rsp_found_score;
   logic                      rsp_written;

   search_result_table #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_key(req_key),
      .req_entry_score(req_entry_score),
      .req_bound_type(req_bound_type),
      .req_search_depth(req_search_depth),
      .req_window_low(req_window_low),
      .req_window_high(req_window_high),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_hit(rsp_hit),
      .rsp_found_score(rsp_found_score),
      .rsp_written(rsp_written)
   );

   // Shadow copy of the table contents
   logic                      tt_valid [TABLE_ENTRIES];
   logic [KEY_W-1:0]          tt_key   [TABLE_ENTRIES];
   logic signed [SCORE_W-1:0] tt_score [TABLE_ENTRIES];
   logic [DEPTH_W-1:0]        tt_depth [TABLE_ENTRIES];
   logic [KIND_W-1:0]         tt_kind  [TABLE_ENTRIES];

   item_type   pending_items[$];
   result_type expected_answers[$];
   item_type   offered;
   int         send_pause     = 0;
   int         items_loaded   = 0;
   int         hold_left      = 0;
   int         long_hold      = 0;
   int         answers_taken  = 0;
   int         idle_cycles    = 0;
   int         fail_count     = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic item_type make_item(logic f, logic [KEY_W-1:0] k, int sc,
                                          logic [KIND_W-1:0] kd, int dp, int lo, int hi);
      item_type it;
      it.func  = f;
      it.key   = k;
      it.score = SCORE_W'(sc);
      it.kind  = kd;
      it.depth = DEPTH_W'(dp);
      it.alpha = SCORE_W'(lo);
      it.beta  = SCORE_W'(hi);
      return it;
   endfunction

   // Depth-preferred store or windowed probe against the shadow table
   function automatic result_type apply_table_access(item_type it);
      result_type                res;
      int unsigned               idx;
      logic                      same_key;
      logic signed [SCORE_W-1:0] stored, lo, hi;
      res      = '0;
      idx      = int'(it.key % KEY_W'(TABLE_ENTRIES));
      same_key = tt_valid[idx] && (tt_key[idx] == it.key);
      if (it.func == FUNC_STORE) begin
         if (!same_key || tt_depth[idx] < it.depth) begin
            tt_valid[idx] = 1'b1;
            tt_key[idx]   = it.key;
            tt_score[idx] = it.score;
            tt_depth[idx] = it.depth;
            tt_kind[idx]  = it.kind;
            res.written   = 1'b1;
         end
      end else if (same_key && tt_depth[idx] >= it.depth) begin
         stored = tt_score[idx];
         lo     = it.alpha;
         hi     = it.beta;
         if (tt_kind[idx] == KIND_EXACT) begin
            res.hit = 1'b1;
         end else begin
            if (tt_kind[idx] == KIND_LOWER && stored > lo)
               lo = stored;
            else if (tt_kind[idx] == KIND_UPPER && stored < hi)
               hi = stored;
            res.hit = (lo >= hi);
         end
         if (res.hit)
            res.found_score = stored;
      end
      return res;
   endfunction

   // Sender pause after each item; every hundred items start with a burst
   function automatic int draw_send_pause(int n);
      if ((n % 100) < 20)
         return 0;
      return $urandom_range(0, 19);
   endfunction

   // Receiver hold-off after each result, with a stretch of none per hundred
   function automatic int draw_hold(int n);
      if ((n % 100) >= 50 && (n % 100) < 70)
         return 0;
      return $urandom_range(0, 19);
   endfunction

   // Stimulus, reset and end of run
   initial begin
      logic [KEY_W-1:0] key_pool[POOL_SIZE];
      logic [KEY_W-1:0] k, k_far, k_alias, k_odd;
      int               dp;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         tt_valid[i] = 1'b0;
         tt_key[i]   = '0;
         tt_score[i] = '0;
         tt_depth[i] = '0;
         tt_kind[i]  = KIND_EXACT;
      end

      // Directed: bounds, depth preference, collisions, closed windows
      k_far   = '1;
      k_alias = KEY_W'(TABLE_ENTRIES) << 40;
      k_odd   = 64'h5555_AAAA_5555_A3C1;
      pending_items.push_back(make_item(FUNC_PROBE, '0, 0, KIND_EXACT, 0, -32768, 32767));
      pending_items.push_back(make_item(FUNC_STORE, '0, -32768, KIND_EXACT, 0, 0, 0));
      pending_items.push_back(make_item(FUNC_PROBE, '0, 0, KIND_EXACT, 0, -32768, 32767));
      pending_items.push_back(make_item(FUNC_PROBE, '0, 0, KIND_EXACT, 1, -32768, 32767));
      pending_items.push_back(make_item(FUNC_STORE, '0, 5, KIND_EXACT, 0, 0, 0));
      pending_items.push_back(make_item(FUNC_STORE, '0, 100, KIND_LOWER, 10, 0, 0));
      pending_items.push_back(make_item(FUNC_PROBE, '0, 0, KIND_EXACT, 10, 0, 100));
      pending_items.push_back(make_item(FUNC_PROBE, '0, 0, KIND_EXACT, 3, 0, 101));
      pending_items.push_back(make_item(FUNC_STORE, '0, 1, KIND_EXACT, 9, 0, 0));
      pending_items.push_back(make_item(FUNC_STORE, k_alias, 32767, KIND_UPPER, 0, 0, 0));
      pending_items.push_back(make_item(FUNC_PROBE, '0, 0, KIND_EXACT, 0, -32768, 32767));
      pending_items.push_back(make_item(FUNC_PROBE, k_alias, 0, KIND_EXACT, 0, 32767, 32767));
      pending_items.push_back(make_item(FUNC_PROBE, k_alias, 0, KIND_EXACT, 0, -32768, 32767));
      pending_items.push_back(make_item(FUNC_STORE, k_far, -50, KIND_UPPER, 255, 0, 0));
      pending_items.push_back(make_item(FUNC_PROBE, k_far, 0, KIND_EXACT, 255, -50, 0));
      pending_items.push_back(make_item(FUNC_PROBE, k_far, 0, KIND_EXACT, 255, -51, 0));
      pending_items.push_back(make_item(FUNC_STORE, k_far, 7, KIND_EXACT, 255, 0, 0));
      pending_items.push_back(make_item(FUNC_STORE, k_odd, 1234, KIND_RESERVED, 128, 0, 0));
      pending_items.push_back(make_item(FUNC_PROBE, k_odd, 0, KIND_EXACT, 128, 0, 10));
      pending_items.push_back(make_item(FUNC_PROBE, k_odd, 0, KIND_EXACT, 128, 10, 10));
      pending_items.push_back(make_item(FUNC_PROBE, k_odd, 0, KIND_EXACT, 0, 32767, -32768));
      pending_items.push_back(make_item(FUNC_PROBE, ~k_odd, -1, KIND_UPPER, 255, -1, -1));
      pending_items.push_back(make_item(FUNC_STORE, ~k_odd, 32767, KIND_EXACT, 200,
                                        -32768, 32767));
      pending_items.push_back(make_item(FUNC_PROBE, ~k_odd, -7, KIND_RESERVED, 200,
                                        32767, -32768));

      // Key pool with every second key aliasing its neighbour's slot
      for (int i = 0; i < POOL_SIZE; i++) begin
         key_pool[i] = {$urandom, $urandom};
         if (i % 2 == 1)
            key_pool[i] = key_pool[i] - (key_pool[i] % KEY_W'(TABLE_ENTRIES))
                          + (key_pool[i-1] % KEY_W'(TABLE_ENTRIES));
      end

      // Random: mostly stores and probes on pooled keys, some stray keys
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if ($urandom_range(0, 99) < 85)
            k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         else
            k = {$urandom, $urandom};
         if ($urandom_range(0, 9) == 0)
            dp = $urandom_range(0, 255);
         else
            dp = $urandom_range(0, 7);
         pending_items.push_back(make_item($urandom_range(0, 1) ? FUNC_STORE : FUNC_PROBE, k,
                                           int'($urandom), KIND_W'($urandom_range(0, 3)), dp,
                                           int'($urandom), int'($urandom)));
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_valid || expected_answers.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("PASS search_result_table");
      else
         $display("FAIL search_result_table");
      $finish;
   end

   // Sender: one transfer per item, then a drawn pause
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         send_pause <= 0;
      end else begin
         if (req_valid && !req_stall)
            expected_answers.push_back(apply_table_access(offered));
         if (!req_valid || !req_stall) begin
            if (send_pause > 0) begin
               send_pause <= send_pause - 1;
               req_valid  <= 1'b0;
            end else if (pending_items.size() != 0) begin
               offered = pending_items.pop_front();
               req_func         <= offered.func;
               req_key          <= offered.key;
               req_entry_score  <= offered.score;
               req_bound_type   <= offered.kind;
               req_search_depth <= offered.depth;
               req_window_low   <= offered.alpha;
               req_window_high  <= offered.beta;
               req_valid        <= 1'b1;
               send_pause       <= draw_send_pause(items_loaded);
               items_loaded++;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: check each result transfer, then hold off for a drawn time
   always @(posedge clock) begin : receiver
      result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
         long_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_answers.size() == 0) begin
               $error("result transfer with nothing outstanding");
               fail_count++;
            end else begin
               want = expected_answers.pop_front();
               if (rsp_hit !== want.hit) begin
                  $error("hit: expected %0b, got %0b", want.hit, rsp_hit);
                  fail_count++;
               end
               if (rsp_found_score !== want.found_score) begin
                  $error("found_score: expected %0d, got %0d", want.found_score,
                         rsp_found_score);
                  fail_count++;
               end
               if (rsp_written !== want.written) begin
                  $error("written: expected %0b, got %0b", want.written, rsp_written);
                  fail_count++;
               end
            end
            answers_taken++;
            hold_left = draw_hold(answers_taken);
            // one long hold-off so the block fills and stalls its input
            if (answers_taken == 200)
               long_hold = 300;
         end else if (hold_left > 0) begin
            hold_left--;
         end
         if (long_hold > 0)
            long_hold--;
         rsp_stall <= (hold_left > 0) || (long_hold > 0);
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL search_result_table");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
